>>> rtl/pmte_pkg.sv
// ----------------------------------------------------------------------------
// pmte_pkg : shared definitions for the PRBS memory test engine
// Word widths, LFSR taps, reset seed, stream field offsets and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pmte_pkg;

  localparam int WORD_BITS  = 32;
  localparam int ADDR_SHIFT = 2;                       // byte stride of 4 per word
  localparam int IDX_BITS   = WORD_BITS - ADDR_SHIFT;  // index bits that reach the address

  localparam logic [WORD_BITS-1:0] PRBS_TAPS  = 32'h8020_0003;
  localparam logic [WORD_BITS-1:0] SEED_RESET = 32'hACE1_ACE1;
  localparam logic [WORD_BITS-1:0] COUNT_MAX  = {WORD_BITS{1'b1}};

  // register indexes of the write port
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LFSR_SEED    = 1'b1;

  // input stream: tuser bit positions
  localparam int IN_USER_BITS  = 2;
  localparam int IN_USER_MODE  = 0;
  localparam int IN_USER_START = 1;

  // output stream: tdata field offsets, lowest first
  localparam int OUT_DATA_BITS  = 6 * WORD_BITS;
  localparam int OUT_ADDR_LO    = 0;
  localparam int OUT_PAT_LO     = 1 * WORD_BITS;
  localparam int OUT_COUNT_LO   = 2 * WORD_BITS;
  localparam int OUT_FADDR_LO   = 3 * WORD_BITS;
  localparam int OUT_FEXP_LO    = 4 * WORD_BITS;
  localparam int OUT_FGOT_LO    = 5 * WORD_BITS;
  localparam int OUT_USER_BITS  = 1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t first_got;
    word_t first_expected;
    word_t first_address;
    word_t error_count;
    word_t pattern_word;
    word_t word_address;
  } result_t;

  // one step of the right-shifting Galois LFSR
  function automatic word_t lfsr_advance(input word_t s);
    word_t fb;
    fb = s[0] ? PRBS_TAPS : '0;
    return (s >> 1) ^ fb;
  endfunction

endpackage

`default_nettype wire

>>> rtl/prbs_memory_test_engine.sv
// ----------------------------------------------------------------------------
// prbs_memory_test_engine : PRBS pattern generator and read-back checker
// Emits address and pattern for each word of a region, compares read-back
// words against the regenerated pattern and keeps a first-failure record.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                  Contents
//  --------  ---  -------------------------  ---------------------------------
//  s_axis    in   tvalid / tready            tdata: read_word; tlast: last_word;
//                                            tuser: mode, start_req
//  m_axis    out  tvalid / tready            tdata: address, pattern, count,
//                                            first-failure record; tlast: run_done;
//                                            tuser: mismatch
//  cfg       in   cfg_write (no wait)        0: base_address, 1: lfsr_seed
//
//  One word per cycle sustained while m_axis is not stalled: a word is first
//  held in the input register, then the LFSR step, one 32-bit address add and
//  the compare load the result register, which raises tvalid.
//  Reset (rst, synchronous) empties both registers, loads the default seed and
//  clears the index and the error record; no clearing pass is needed.
//  A stalled output holds its word and stops the input register from moving;
//  s_axis_tready stays high while the input register can drain or is empty.
//
`default_nettype none

module prbs_memory_test_engine (
  input  wire                              clk,
  input  wire                              rst,
  // configuration write port
  input  wire                              cfg_write,
  input  wire [pmte_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [pmte_pkg::WORD_BITS-1:0]    cfg_data,
  // input words
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [pmte_pkg::WORD_BITS-1:0]    s_axis_tdata,   // [31:0] read_word
  input  wire                              s_axis_tlast,   // last_word
  input  wire [pmte_pkg::IN_USER_BITS-1:0] s_axis_tuser,   // [0] mode, [1] start_req
  // result words
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [31:0] word_address, [63:32] pattern_word, [95:64] error_count,
  // [127:96] first_address, [159:128] first_expected, [191:160] first_got
  output logic [pmte_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,   // run_done
  output logic [pmte_pkg::OUT_USER_BITS-1:0] m_axis_tuser  // [0] mismatch
);

  import pmte_pkg::*;

  // configuration registers
  word_t base_address;
  word_t lfsr_seed;

  // input register
  logic  in_valid;
  logic  in_mode;
  logic  in_start;
  logic  in_last;
  word_t in_data;

  // run state
  word_t                lfsr_state;
  logic [IDX_BITS-1:0]  word_index;
  word_t                error_total;
  word_t                first_fail_address;
  word_t                first_fail_expected;
  word_t                first_fail_got;

  // result register
  logic    out_valid;
  logic    out_mismatch;
  logic    out_last;
  result_t out_result;

  logic advance;

  // state as seen by the held word, cleared and reseeded if it starts a run
  word_t               cur_lfsr;
  logic [IDX_BITS-1:0] cur_index;
  word_t               cur_total;
  word_t               cur_faddr;
  word_t               cur_fexp;
  word_t               cur_fgot;

  word_t               word_addr;
  logic                miss;
  logic                first_hit;

  word_t               lfsr_state_next;
  logic [IDX_BITS-1:0] word_index_next;
  word_t               error_total_next;
  word_t               first_fail_address_next;
  word_t               first_fail_expected_next;
  word_t               first_fail_got_next;

  // move the held word on when the result register is free or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    // a start request reseeds and wipes the record before this word
    cur_lfsr  = in_start ? lfsr_seed : lfsr_state;
    cur_index = in_start ? '0 : word_index;
    cur_total = in_start ? '0 : error_total;
    cur_faddr = in_start ? '0 : first_fail_address;
    cur_fexp  = in_start ? '0 : first_fail_expected;
    cur_fgot  = in_start ? '0 : first_fail_got;

    // address wraps modulo 2^32, so only the low index bits matter
    word_addr = base_address + {cur_index, {ADDR_SHIFT{1'b0}}};
    miss      = in_mode && (in_data != cur_lfsr);
    first_hit = miss && (cur_total == '0);

    error_total_next         = (miss && (cur_total != COUNT_MAX)) ? cur_total + 1'b1
                                                                  : cur_total;
    first_fail_address_next  = first_hit ? word_addr : cur_faddr;
    first_fail_expected_next = first_hit ? cur_lfsr  : cur_fexp;
    first_fail_got_next      = first_hit ? in_data   : cur_fgot;

    // end of region: rewind for the next pass, keep the error record
    lfsr_state_next = in_last ? lfsr_seed : lfsr_advance(cur_lfsr);
    word_index_next = in_last ? '0 : cur_index + 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      lfsr_seed    <= SEED_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS: base_address <= cfg_data;
        CFG_LFSR_SEED:    lfsr_seed    <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode  <= s_axis_tuser[IN_USER_MODE];
      in_start <= s_axis_tuser[IN_USER_START];
      in_last  <= s_axis_tlast;
      in_data  <= s_axis_tdata;
    end
  end

  // run state: update once per word passed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_state          <= SEED_RESET;
      word_index          <= '0;
      error_total         <= '0;
      first_fail_address  <= '0;
      first_fail_expected <= '0;
      first_fail_got      <= '0;
    end else if (advance) begin
      lfsr_state          <= lfsr_state_next;
      word_index          <= word_index_next;
      error_total         <= error_total_next;
      first_fail_address  <= first_fail_address_next;
      first_fail_expected <= first_fail_expected_next;
      first_fail_got      <= first_fail_got_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mismatch                  <= miss;
      out_last                      <= in_last;
      out_result.word_address       <= word_addr;
      out_result.pattern_word       <= cur_lfsr;
      out_result.error_count        <= error_total_next;
      out_result.first_address      <= first_fail_address_next;
      out_result.first_expected     <= first_fail_expected_next;
      out_result.first_got          <= first_fail_got_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_mismatch;

endmodule

`default_nettype wire

>>> rtl/pmte_checker.sv
// ----------------------------------------------------------------------------
// pmte_checker : port-level checks for the PRBS memory test engine
// Watches the result stream for record consistency and output stability.
// ----------------------------------------------------------------------------
`default_nettype none

module pmte_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [pmte_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire [pmte_pkg::OUT_USER_BITS-1:0] m_axis_tuser
);

  import pmte_pkg::*;

  word_t addr;
  word_t pat;
  word_t count;
  word_t faddr;
  word_t fexp;
  word_t fgot;

  assign addr  = m_axis_tdata[OUT_ADDR_LO  +: WORD_BITS];
  assign pat   = m_axis_tdata[OUT_PAT_LO   +: WORD_BITS];
  assign count = m_axis_tdata[OUT_COUNT_LO +: WORD_BITS];
  assign faddr = m_axis_tdata[OUT_FADDR_LO +: WORD_BITS];
  assign fexp  = m_axis_tdata[OUT_FEXP_LO  +: WORD_BITS];
  assign fgot  = m_axis_tdata[OUT_FGOT_LO  +: WORD_BITS];

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a flagged mismatch is always counted
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> count != '0)
    else $error("mismatch without error count");

  // no errors means an empty first-failure record
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (count == '0) |-> (faddr == '0) && (fexp == '0) && (fgot == '0))
    else $error("first-failure record set with zero count");

  // the first mismatch of a run is the one latched
  a_first_latch: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] && (count == 32'd1)
      |-> (faddr == addr) && (fexp == pat) && (fgot != pat))
    else $error("first mismatch not latched");

endmodule

bind prbs_memory_test_engine pmte_checker u_pmte_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
